>>> rtl/tcc_pkg.sv
// Shared types, constants and codes of the capture/compare timer.
package tcc_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int CHANNELS_DEF    = 5;
   localparam int FIELD_WIDTH     = 16;
   localparam int PIN_WIDTH       = 5;
   localparam int CHAN_SEL_WIDTH  = 3;
   localparam int CTL_WIDTH       = 6;
   localparam int MODE_REG_WIDTH  = 2;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 6;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TIMER_MODE  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CH0_CONTROL = 3'd1;

   // Bit positions inside a channel control register.
   localparam int CTL_EDGE_RISE_BIT = 0;
   localparam int CTL_EDGE_FALL_BIT = 1;
   localparam int CTL_COMPARE_BIT   = 2;
   localparam int CTL_ACTION_LSB    = 3;
   localparam int CTL_ACTION_MSB    = 5;

   typedef enum logic [MODE_REG_WIDTH-1:0] {
      TM_STOP   = 2'd0,
      TM_FREE   = 2'd1,
      TM_MODULO = 2'd2,
      TM_UPDOWN = 2'd3
   } timer_mode_type;

   typedef enum logic {
      ITEM_TICK = 1'b0,
      ITEM_LOAD = 1'b1
   } item_mode_type;

   typedef enum logic [2:0] {
      ACT_SET_TOP = 3'd0,
      ACT_CLR_TOP = 3'd1,
      ACT_TGL_TOP = 3'd2,
      ACT_EDGE_HI = 3'd3,
      ACT_EDGE_LO = 3'd4,
      ACT_PWM_HI  = 3'd5,
      ACT_PWM_LO  = 3'd6,
      ACT_CLEAR   = 3'd7
   } action_type;

   typedef struct packed {
      logic           tick;
      logic           load;
      timer_mode_type timer_mode;
      logic           down;
   } chan_ctl_type;

   typedef struct packed {
      logic capture;
      logic pin_next;
   } chan_status_type;

endpackage

>>> rtl/tcc_if.sv
// Request and response channel interfaces of the capture/compare timer.
interface tcc_req_if;
   import tcc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      mode;
   logic [PIN_WIDTH-1:0]      pin_levels;
   logic [CHAN_SEL_WIDTH-1:0] channel;
   logic [FIELD_WIDTH-1:0]    value;

   modport source (output valid, mode, pin_levels, channel, value, input ready);
   modport sink (input valid, mode, pin_levels, channel, value, output ready);
endinterface

interface tcc_rsp_if;
   import tcc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [FIELD_WIDTH-1:0] counter;
   logic [PIN_WIDTH-1:0]   out_pins;
   logic [PIN_WIDTH-1:0]   capture_flags;
   logic                   overflow;
   logic                   counting_down;

   modport source (output valid, counter, out_pins, capture_flags, overflow, counting_down,
                   input ready);
   modport sink (input valid, counter, out_pins, capture_flags, overflow, counting_down,
                 output ready);
endinterface

>>> rtl/tcc_counter.sv
// Counter register with its mode-dependent next-count, direction and overflow logic.
module tcc_counter #(
   parameter int COUNT_WIDTH = tcc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  tcc_pkg::timer_mode_type   timer_mode,
   input  logic [COUNT_WIDTH-1:0]    top_value,
   output logic [COUNT_WIDTH-1:0]    count_in,
   output logic                      down_in,
   output logic                      overflow
);
   import tcc_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic                   down_ff;
   logic [COUNT_WIDTH-1:0] incr;
   logic [COUNT_WIDTH-1:0] decr;

   assign incr = count_ff + 1'b1;
   assign decr = count_ff - 1'b1;

   always_comb begin
      count_in = count_ff;
      down_in  = down_ff;
      overflow = 1'b0;
      if (step) begin
         unique case (timer_mode)
            TM_STOP: begin
               count_in = count_ff;
            end
            TM_FREE: begin
               count_in = incr;
               overflow = (incr == '0);
            end
            TM_MODULO: begin
               if (count_ff == top_value) begin
                  count_in = '0;
                  overflow = 1'b1;
               end else begin
                  count_in = incr;
                  overflow = (incr == '0);
               end
            end
            TM_UPDOWN: begin
               // The turn at the top is taken on the tick that reaches it.
               if (!down_ff) begin
                  count_in = incr;
                  overflow = (incr == '0);
                  if (incr == top_value) down_in = 1'b1;
               end else begin
                  count_in = decr;
                  if (decr == '0) begin
                     overflow = 1'b1;
                     down_in  = 1'b0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         down_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         down_ff  <= down_in;
      end
   end

endmodule

>>> rtl/tcc_channel.sv
// One capture/compare channel: value register, edge detector and output pin logic.
module tcc_channel #(
   parameter int COUNT_WIDTH = tcc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tcc_pkg::chan_ctl_type           ctl,
   input  logic [tcc_pkg::CTL_WIDTH-1:0]   control,
   input  logic                            first_channel,
   input  logic                            pin_level,
   input  logic [COUNT_WIDTH-1:0]          load_value,
   input  logic [COUNT_WIDTH-1:0]          count,
   input  logic [COUNT_WIDTH-1:0]          top_value,
   output logic [COUNT_WIDTH-1:0]          value,
   output tcc_pkg::chan_status_type        status
);
   import tcc_pkg::*;

   logic [COUNT_WIDTH-1:0] value_ff;
   logic [COUNT_WIDTH-1:0] value_in;
   logic                   prev_ff;
   logic                   prev_in;
   logic                   pin_ff;
   logic                   pin_in;
   logic                   pin_act;
   logic                   compare_mode;
   logic                   capture;
   logic                   at_top;
   logic                   at_own;
   logic                   at_zero;
   logic                   hit;
   logic                   edge_hi;
   logic                   pwm_hi;
   action_type             action;

   assign compare_mode = control[CTL_COMPARE_BIT];
   assign action       = action_type'(control[CTL_ACTION_MSB:CTL_ACTION_LSB]);
   assign edge_hi      = (action == ACT_EDGE_HI);
   assign pwm_hi       = (action == ACT_PWM_HI);

   assign capture = ctl.tick && !compare_mode && (pin_level != prev_ff) &&
                    (pin_level ? control[CTL_EDGE_RISE_BIT] : control[CTL_EDGE_FALL_BIT]);

   assign at_top  = (count == top_value);
   assign at_own  = (count == value_ff);
   assign at_zero = (count == '0);
   assign hit     = at_top || at_own || at_zero;

   always_comb begin
      pin_act = pin_ff;
      case (action) inside
         ACT_SET_TOP: begin
            if (at_top) pin_act = 1'b1;
         end
         ACT_CLR_TOP: begin
            if (at_top) pin_act = 1'b0;
         end
         ACT_TGL_TOP: begin
            if (at_top) pin_act = !pin_ff;
         end
         ACT_EDGE_HI, ACT_EDGE_LO: begin
            if (ctl.timer_mode == TM_UPDOWN) begin
               // Center-aligned: the level follows which side of the own value we are on.
               if (at_own) pin_act = ctl.down ? !edge_hi : edge_hi;
               else if (count > value_ff) pin_act = edge_hi;
               else pin_act = !edge_hi;
            end else begin
               if (at_own) pin_act = edge_hi;
               if (at_zero) pin_act = !edge_hi;
            end
         end
         ACT_PWM_HI, ACT_PWM_LO: begin
            if (!first_channel) begin
               if (ctl.timer_mode == TM_MODULO) begin
                  if (at_own) pin_act = pwm_hi;
                  if (at_zero) pin_act = !pwm_hi;
               end else begin
                  if (at_top) pin_act = !pwm_hi;
                  if (at_own) pin_act = pwm_hi;
               end
            end
         end
         default: begin
            pin_act = 1'b0;
         end
      endcase
   end

   assign pin_in  = (ctl.tick && compare_mode && hit) ? pin_act : pin_ff;
   assign prev_in = (ctl.tick && !compare_mode) ? pin_level : prev_ff;

   always_comb begin
      value_in = value_ff;
      if (ctl.load) value_in = load_value;
      else if (capture) value_in = count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         prev_ff  <= 1'b0;
         pin_ff   <= 1'b0;
      end else begin
         value_ff <= value_in;
         prev_ff  <= prev_in;
         pin_ff   <= pin_in;
      end
   end

   assign value           = value_ff;
   assign status.capture  = capture;
   assign status.pin_next = pin_in;

endmodule

>>> rtl/timer_capture_compare.sv
// A word accepted into the input register has its result registered in the result register
// once that register is free or drains; the response is presented from the result register.
// Throughput: one word per cycle while the response side keeps taking results; the counter
// and every channel update in a single pass from the input register to the result register.
// Reset is synchronous and clears the counter, direction, channel values, pins and
// configuration registers at once; no word is held off after reset.
module timer_capture_compare #(
   parameter int CHANNELS    = tcc_pkg::CHANNELS_DEF,
   parameter int COUNT_WIDTH = tcc_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   tcc_req_if.sink                               req_chan,
   tcc_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_enable,
   input  logic [tcc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tcc_pkg::CSR_DATA_WIDTH-1:0]    csr_write_data
);
   import tcc_pkg::*;

   timer_mode_type            timer_mode_ff;
   logic [CTL_WIDTH-1:0]      control_ff [CHANNELS];

   logic                      in_valid_ff;
   logic                      in_valid_in;
   item_mode_type             in_mode_ff;
   logic [PIN_WIDTH-1:0]      in_pins_ff;
   logic [CHAN_SEL_WIDTH-1:0] in_channel_ff;
   logic [COUNT_WIDTH-1:0]    in_value_ff;

   logic                      out_valid_ff;
   logic                      out_valid_in;
   logic [FIELD_WIDTH-1:0]    rsp_counter_ff;
   logic [PIN_WIDTH-1:0]      rsp_pins_ff;
   logic [PIN_WIDTH-1:0]      rsp_flags_ff;
   logic                      rsp_overflow_ff;
   logic                      rsp_down_ff;

   logic                      accept_in;
   logic                      advance;
   logic                      step;
   logic                      load;
   logic [COUNT_WIDTH-1:0]    count_in;
   logic                      down_in;
   logic                      overflow;
   logic [COUNT_WIDTH-1:0]    top_eff;
   logic [COUNT_WIDTH-1:0]    chan_value [CHANNELS];
   chan_status_type           chan_status [CHANNELS];
   chan_ctl_type              chan_ctl [CHANNELS];
   logic [PIN_WIDTH-1:0]      pins_next;
   logic [PIN_WIDTH-1:0]      flags_next;

   // Handshake: the input register moves on whenever the result register is free or drains.
   assign accept_in      = req_chan.valid && req_chan.ready;
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = accept_in || (in_valid_ff && !advance);
   assign out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);

   assign step = advance && (in_mode_ff == ITEM_TICK) && (timer_mode_ff != TM_STOP);
   assign load = advance && (in_mode_ff == ITEM_LOAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff <= TM_STOP;
         for (int i = 0; i < CHANNELS; i++) control_ff[i] <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == REG_TIMER_MODE) begin
            timer_mode_ff <= timer_mode_type'(csr_write_data[MODE_REG_WIDTH-1:0]);
         end
         for (int i = 0; i < CHANNELS; i++) begin
            if (csr_index == REG_CH0_CONTROL + CSR_INDEX_WIDTH'(i)) begin
               control_ff[i] <= csr_write_data[CTL_WIDTH-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_mode_ff    <= item_mode_type'(req_chan.mode);
         in_pins_ff    <= req_chan.pin_levels;
         in_channel_ff <= req_chan.channel;
         in_value_ff   <= req_chan.value[COUNT_WIDTH-1:0];
      end
   end

   tcc_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counter (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .timer_mode (timer_mode_ff),
      .top_value  (chan_value[0]),
      .count_in   (count_in),
      .down_in    (down_in),
      .overflow   (overflow)
   );

   // A capture on channel 0 moves the top value that later channels compare against.
   assign top_eff = chan_status[0].capture ? count_in : chan_value[0];

   for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
      assign chan_ctl[g].tick       = step;
      assign chan_ctl[g].load       = load && (in_channel_ff == CHAN_SEL_WIDTH'(g));
      assign chan_ctl[g].timer_mode = timer_mode_ff;
      assign chan_ctl[g].down       = down_in;

      tcc_channel #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_channel (
         .clock         (clock),
         .reset         (reset),
         .ctl           (chan_ctl[g]),
         .control       (control_ff[g]),
         .first_channel (g == 0),
         .pin_level     (in_pins_ff[g]),
         .load_value    (in_value_ff),
         .count         (count_in),
         .top_value     (top_eff),
         .value         (chan_value[g]),
         .status        (chan_status[g])
      );
   end

   always_comb begin
      pins_next  = '0;
      flags_next = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         pins_next[i]  = chan_status[i].pin_next;
         flags_next[i] = chan_status[i].capture;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_counter_ff  <= FIELD_WIDTH'(count_in);
         rsp_pins_ff     <= pins_next;
         rsp_flags_ff    <= flags_next;
         rsp_overflow_ff <= overflow;
         rsp_down_ff     <= down_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.counter       = rsp_counter_ff;
   assign rsp_chan.out_pins      = rsp_pins_ff;
   assign rsp_chan.capture_flags = rsp_flags_ff;
   assign rsp_chan.overflow      = rsp_overflow_ff;
   assign rsp_chan.counting_down = rsp_down_ff;

`ifndef SYNTHESIS
   a_load_quiet : assert property (@(posedge clock) disable iff (reset)
      advance && (in_mode_ff == ITEM_LOAD) |=>
         (rsp_chan.capture_flags == '0) && !rsp_chan.overflow)
      else $error("load word produced a capture flag or overflow");

   a_stop_hold : assert property (@(posedge clock) disable iff (reset)
      advance && (in_mode_ff == ITEM_TICK) && (timer_mode_ff == TM_STOP) |=>
         (rsp_chan.capture_flags == '0) && !rsp_chan.overflow &&
         (rsp_chan.counter == $past(FIELD_WIDTH'(count_in))))
      else $error("stopped timer changed on a tick");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> in_valid_ff && out_valid_ff && !rsp_chan.ready)
      else $error("request side stalled without a blocked response");

   a_result_moves : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_chan.valid)
      else $error("advanced word did not reach the response register");
`endif

endmodule

>>> sim/tb_timer_capture_compare.sv
// Self-checking testbench of the capture/compare timer: directed cases, counting runs, random words.
module tb_timer_capture_compare;
   import tcc_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;

   // Capture edge selections in the low bits of a channel control register.
   localparam logic [CTL_WIDTH-1:0] CAP_NONE = 6'd0;
   localparam logic [CTL_WIDTH-1:0] CAP_RISE = 6'd1;
   localparam logic [CTL_WIDTH-1:0] CAP_FALL = 6'd2;
   localparam logic [CTL_WIDTH-1:0] CAP_BOTH = 6'd3;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] counter;
      logic [PIN_WIDTH-1:0]   out_pins;
      logic [PIN_WIDTH-1:0]   capture_flags;
      logic                   overflow;
      logic                   counting_down;
   } timer_report_type;

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   tcc_req_if req_if();
   tcc_rsp_if rsp_if();

   timer_capture_compare dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the timer state and its configuration.
   timer_mode_type         run_mode;
   logic [CTL_WIDTH-1:0]   chan_ctl [CHANNELS];
   logic [FIELD_WIDTH-1:0] count_now;
   logic                   going_down;
   logic [FIELD_WIDTH-1:0] chan_value [CHANNELS];
   logic [CHANNELS-1:0]    last_pin;
   logic [CHANNELS-1:0]    drive_pin;

   timer_report_type timer_reports [$];
   int               mismatches = 0;
   int               gap_pct;
   int               stall_pct;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [CTL_WIDTH-1:0] compare_ctl(input action_type act);
      return {act, 1'b1, 2'b00};
   endfunction

   // New level of a compare pin on a compare hit.
   function automatic logic apply_compare(input int ch, input logic pin);
      action_type             act;
      logic                   hi;
      logic [FIELD_WIDTH-1:0] own;
      act = action_type'(chan_ctl[ch][CTL_ACTION_MSB:CTL_ACTION_LSB]);
      own = chan_value[ch];
      case (act)
         ACT_SET_TOP: if (count_now == chan_value[0]) pin = 1'b1;
         ACT_CLR_TOP: if (count_now == chan_value[0]) pin = 1'b0;
         ACT_TGL_TOP: if (count_now == chan_value[0]) pin = ~pin;
         ACT_EDGE_HI, ACT_EDGE_LO: begin
            hi = (act == ACT_EDGE_HI);
            if (run_mode == TM_UPDOWN) begin
               if (count_now == own) pin = going_down ? !hi : hi;
               else if (count_now > own) pin = hi;
               else pin = !hi;
            end else begin
               if (count_now == own) pin = hi;
               if (count_now == '0) pin = !hi;
            end
         end
         ACT_PWM_HI, ACT_PWM_LO: begin
            hi = (act == ACT_PWM_HI);
            // Channel 0 holds the period, so these actions leave its pin alone.
            if (ch != 0) begin
               if (run_mode == TM_MODULO) begin
                  if (count_now == own) pin = hi;
                  if (count_now == '0) pin = !hi;
               end else begin
                  if (count_now == chan_value[0]) pin = !hi;
                  if (count_now == own) pin = hi;
               end
            end
         end
         ACT_CLEAR: pin = 1'b0;
      endcase
      return pin;
   endfunction

   // Advances the shadow timer by one word and returns the report it produces.
   function automatic timer_report_type step_timer(input item_mode_type kind,
                                                   input logic [PIN_WIDTH-1:0] pins,
                                                   input logic [CHAN_SEL_WIDTH-1:0] chan,
                                                   input logic [FIELD_WIDTH-1:0] val);
      timer_report_type       rep;
      logic [FIELD_WIDTH-1:0] nxt;
      logic                   cap;
      rep = '0;
      if (kind == ITEM_LOAD) begin
         if (chan < CHANNELS) chan_value[chan] = val;
      end else if (run_mode != TM_STOP) begin
         nxt = count_now;
         case (run_mode)
            TM_FREE: begin
               nxt = nxt + 1'b1;
               rep.overflow = (nxt == '0);
            end
            TM_MODULO: begin
               if (nxt == chan_value[0]) begin
                  nxt = '0;
                  rep.overflow = 1'b1;
               end else begin
                  nxt = nxt + 1'b1;
                  rep.overflow = (nxt == '0);
               end
            end
            default: begin
               if (!going_down) begin
                  nxt = nxt + 1'b1;
                  rep.overflow = (nxt == '0);
                  if (nxt == chan_value[0]) going_down = 1'b1;
               end else begin
                  nxt = nxt - 1'b1;
                  if (nxt == '0) begin
                     rep.overflow = 1'b1;
                     going_down = 1'b0;
                  end
               end
            end
         endcase
         count_now = nxt;
         for (int i = 0; i < CHANNELS; i++) begin
            if (!chan_ctl[i][CTL_COMPARE_BIT]) begin
               if (pins[i] != last_pin[i]) begin
                  cap = pins[i] ? chan_ctl[i][CTL_EDGE_RISE_BIT] : chan_ctl[i][CTL_EDGE_FALL_BIT];
                  last_pin[i] = pins[i];
                  if (cap) begin
                     chan_value[i] = count_now;
                     rep.capture_flags[i] = 1'b1;
                  end
               end
            end else if (count_now == chan_value[0] || count_now == chan_value[i] ||
                         count_now == '0) begin
               drive_pin[i] = apply_compare(i, drive_pin[i]);
            end
         end
      end
      rep.counter = count_now;
      rep.out_pins = drive_pin;
      rep.counting_down = going_down;
      return rep;
   endfunction

   always @(posedge clock) begin
      rsp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(input string label, input logic [FIELD_WIDTH-1:0] want,
                              input logic [FIELD_WIDTH-1:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 40)
            $display("%0t: %s expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin
      timer_report_type due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (timer_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
               $display("%0t: word with no report pending, expected none, actual counter %0h",
                        $time, rsp_if.counter);
         end else begin
            due = timer_reports.pop_front();
            check_field("counter", due.counter, rsp_if.counter);
            check_field("out_pins", FIELD_WIDTH'(due.out_pins), FIELD_WIDTH'(rsp_if.out_pins));
            check_field("capture_flags", FIELD_WIDTH'(due.capture_flags),
                        FIELD_WIDTH'(rsp_if.capture_flags));
            check_field("overflow", FIELD_WIDTH'(due.overflow), FIELD_WIDTH'(rsp_if.overflow));
            check_field("counting_down", FIELD_WIDTH'(due.counting_down),
                        FIELD_WIDTH'(rsp_if.counting_down));
         end
      end
   end

   // Presents one word, waits for it to be taken and records its report.
   task automatic send_word(input item_mode_type kind, input logic [PIN_WIDTH-1:0] pins,
                            input logic [CHAN_SEL_WIDTH-1:0] chan,
                            input logic [FIELD_WIDTH-1:0] val);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= kind;
      req_if.pin_levels <= pins;
      req_if.channel <= chan;
      req_if.value <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      timer_reports.push_back(step_timer(kind, pins, chan, val));
   endtask

   task automatic tick(input logic [PIN_WIDTH-1:0] pins);
      send_word(ITEM_TICK, pins, CHAN_SEL_WIDTH'($urandom), FIELD_WIDTH'($urandom));
   endtask

   task automatic load_value(input logic [CHAN_SEL_WIDTH-1:0] chan,
                             input logic [FIELD_WIDTH-1:0] val);
      send_word(ITEM_LOAD, PIN_WIDTH'($urandom), chan, val);
   endtask

   task automatic wait_for_results;
      req_if.valid <= 1'b0;
      while (timer_reports.size() != 0) @(posedge clock);
   endtask

   // Writes the mode and every channel control once the timer has gone quiet.
   task automatic program_timer(input timer_mode_type mode_sel,
                                input logic [CHANNELS-1:0][CTL_WIDTH-1:0] ctls);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_index <= REG_TIMER_MODE;
      csr_write_data <= CSR_DATA_WIDTH'(mode_sel);
      @(posedge clock);
      run_mode = mode_sel;
      for (int i = 0; i < CHANNELS; i++) begin
         csr_index <= REG_CH0_CONTROL + CSR_INDEX_WIDTH'(i);
         csr_write_data <= ctls[i];
         @(posedge clock);
         chan_ctl[i] = ctls[i];
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_stopped_timer;
      load_value(3'd0, 16'hFFFF);
      load_value(3'd4, 16'h0000);
      // Channels past the last one must ignore loads.
      load_value(3'd7, 16'hFFFF);
      load_value(3'd5, 16'h5A5A);
      tick(5'h1F);
      tick(5'h00);
   endtask

   task automatic test_capture_edges;
      program_timer(TM_FREE, {CAP_RISE, CAP_NONE, CAP_BOTH, CAP_FALL, CAP_RISE});
      tick(5'h1F);
      tick(5'h00);
      tick(5'h0A);
      tick(5'h15);
   endtask

   task automatic test_modulo_compare;
      program_timer(TM_MODULO, {compare_ctl(ACT_CLEAR), compare_ctl(ACT_TGL_TOP),
                                compare_ctl(ACT_EDGE_HI), compare_ctl(ACT_PWM_LO),
                                compare_ctl(ACT_PWM_HI)});
      load_value(3'd0, 16'd6);
      load_value(3'd1, 16'd2);
      load_value(3'd2, 16'd5);
      repeat (5) tick(PIN_WIDTH'($urandom));
   endtask

   task automatic test_updown_compare;
      program_timer(TM_UPDOWN, {compare_ctl(ACT_EDGE_HI), compare_ctl(ACT_EDGE_LO),
                                compare_ctl(ACT_CLR_TOP), compare_ctl(ACT_SET_TOP),
                                compare_ctl(ACT_PWM_LO)});
      load_value(3'd0, 16'd5);
      load_value(3'd3, 16'd4);
      load_value(3'd4, 16'd2);
      repeat (7) tick(PIN_WIDTH'($urandom));
   endtask

   // A short free-running run, then up/down with a top of zero, entered while the direction
   // is still down, so the counter counts down without reaching zero and turning.
   task automatic test_unreachable_top;
      logic [CHANNELS-1:0][CTL_WIDTH-1:0] ctls;
      gap_pct = 0;
      stall_pct = 0;
      ctls = (CHANNELS * CTL_WIDTH)'($urandom);
      ctls[0] = compare_ctl(ACT_TGL_TOP);
      program_timer(TM_FREE, ctls);
      repeat (16) tick(PIN_WIDTH'($urandom));
      load_value(3'd0, 16'd0);
      ctls = (CHANNELS * CTL_WIDTH)'($urandom);
      ctls[0] = compare_ctl(ACT_EDGE_HI);
      program_timer(TM_UPDOWN, ctls);
      repeat (16) tick(PIN_WIDTH'($urandom));
   endtask

   task automatic test_random_traffic(input int gap, input int stall, input int phase);
      logic [CHANNELS-1:0][CTL_WIDTH-1:0] ctls;
      logic [FIELD_WIDTH-1:0]             val;
      timer_mode_type                     mode_sel;
      item_mode_type                      kind;
      int                                 r;
      gap_pct = gap;
      stall_pct = stall;
      for (int s = 0; s < 3; s++) begin
         case (phase * 3 + s)
            0: begin
               mode_sel = TM_UPDOWN;
               ctls = '1;
            end
            1: begin
               mode_sel = TM_STOP;
               ctls = '0;
            end
            default: begin
               mode_sel = timer_mode_type'($urandom_range(1, 3));
               ctls = (CHANNELS * CTL_WIDTH)'($urandom);
            end
         endcase
         program_timer(mode_sel, ctls);
         for (int n = 0; n < 96; n++) begin
            if (n == 48) wait_for_results();
            r = $urandom_range(9);
            // Values near the counter make compare hits and modulo reloads likely.
            if (r < 4) val = FIELD_WIDTH'($urandom_range(31));
            else if (r < 7) val = count_now + FIELD_WIDTH'($urandom_range(8));
            else val = FIELD_WIDTH'($urandom);
            kind = ($urandom_range(4) == 0) ? ITEM_LOAD : ITEM_TICK;
            send_word(kind, PIN_WIDTH'($urandom), CHAN_SEL_WIDTH'($urandom), val);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_if.valid = 1'b0;
      req_if.mode = ITEM_TICK;
      req_if.pin_levels = '0;
      req_if.channel = '0;
      req_if.value = '0;
      run_mode = TM_STOP;
      for (int i = 0; i < CHANNELS; i++) begin
         chan_ctl[i] = '0;
         chan_value[i] = '0;
      end
      count_now = '0;
      going_down = 1'b0;
      last_pin = '0;
      drive_pin = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_stopped_timer();
      test_capture_edges();
      test_modulo_compare();
      test_updown_compare();
      test_unreachable_top();
      test_random_traffic(0, 0, 0);
      test_random_traffic(49, 0, 1);
      test_random_traffic(0, 49, 2);
      test_random_traffic(38, 38, 3);

      wait_for_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #16000000;
      $display("tb: failure");
      $finish;
   end

endmodule

>>> timer_capture_compare.f
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_counter.sv
rtl/tcc_channel.sv
rtl/timer_capture_compare.sv
sim/tb_timer_capture_compare.sv
